// ===== rtl/core/dprs_pkg.sv =====
// ----------------------------------------------------------------------------
// Door poll sequencer package
// Shared widths, codes and word types for the door poll and retry sequencer.
// ----------------------------------------------------------------------------
package dprs_pkg;

  localparam int NUM_DOORS   = 9;
  localparam int MAX_RETRIES = 3;

  localparam int DOOR_W  = $clog2(NUM_DOORS + 1);
  localparam int MASK_W  = NUM_DOORS;
  localparam int RETRY_W = $clog2(MAX_RETRIES + 1);

  localparam logic [DOOR_W-1:0]  FIRST_DOOR  = DOOR_W'(1);
  localparam logic [DOOR_W-1:0]  LAST_DOOR   = DOOR_W'(NUM_DOORS);
  localparam logic [RETRY_W-1:0] RETRY_LIMIT = RETRY_W'(MAX_RETRIES);

  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_REPLY   = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;

  localparam logic [1:0] KIND_QUERY = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [7:0] CODE_POSITION  = 8'h01;
  localparam logic [7:0] CODE_CLOSE     = 8'h03;
  localparam logic [7:0] STATUS_CLOSED  = 8'h01;
  localparam logic [7:0] STATUS_SUCCESS = 8'h00;

  typedef struct packed {
    logic [1:0]        action;
    logic [MASK_W-1:0] skip_mask;
    logic [7:0]        reply_code;
    logic [7:0]        reply_status;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [DOOR_W-1:0] door;
    logic [MASK_W-1:0] fail_mask;
  } out_word_t;

  typedef enum logic [1:0] {
    DEC_NONE,
    DEC_WALK,
    DEC_EMIT
  } dec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic take;
    logic walk;
  } dp_cmd_t;

  typedef struct packed {
    dec_t dec;
    logic walk_done;
  } dp_stat_t;

endpackage

// ===== rtl/core/dprs_datapath.sv =====
// ----------------------------------------------------------------------------
// Door poll sequencer datapath
// Holds the polling state, decides each event and walks past skipped doors.
// ----------------------------------------------------------------------------
module dprs_datapath import dprs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_word_t out_data
);

  logic [DOOR_W-1:0]  current_door, current_door_next;
  logic [DOOR_W-1:0]  retry_door, retry_door_next;
  logic [RETRY_W-1:0] retry_count, retry_count_next;
  logic [MASK_W-1:0]  failed_doors, failed_doors_next;
  logic [MASK_W-1:0]  skipped_doors, skipped_doors_next;
  logic               last_was_close, last_was_close_next;
  logic [DOOR_W-1:0]  walk_door;
  logic [DOOR_W-1:0]  walk_from;
  dec_t               dec;
  out_word_t          emit_word;
  logic               advance_req;
  logic               close_req;
  logic               walk_hit;
  logic [MASK_W-1:0]  current_bit;

  assign current_bit = MASK_W'(1) << (current_door - FIRST_DOOR);
  assign walk_hit    = !skipped_doors[walk_door - FIRST_DOOR];

  assign advance_req = ((in_data.reply_code == CODE_POSITION) &&
                        (in_data.reply_status == STATUS_CLOSED)) ||
                       ((in_data.reply_code == CODE_CLOSE) &&
                        (in_data.reply_status == STATUS_SUCCESS));
  assign close_req   = ((in_data.reply_code == CODE_POSITION) ||
                        (in_data.reply_code == CODE_CLOSE)) && !advance_req;

  always_comb begin
    current_door_next   = current_door;
    retry_door_next     = retry_door;
    retry_count_next    = retry_count;
    failed_doors_next   = failed_doors;
    skipped_doors_next  = skipped_doors;
    last_was_close_next = last_was_close;
    dec                 = DEC_NONE;
    walk_from           = current_door;
    emit_word           = '{kind: KIND_DONE, door: '0, fail_mask: failed_doors};
    case (in_data.action)
      ACT_START: begin
        skipped_doors_next = in_data.skip_mask;
        current_door_next  = FIRST_DOOR;
        failed_doors_next  = '0;
        dec                = DEC_WALK;
        walk_from          = FIRST_DOOR;
      end
      ACT_REPLY: begin
        if (advance_req) begin
          if (current_door < LAST_DOOR) begin
            current_door_next = current_door + FIRST_DOOR;
            walk_from         = current_door + FIRST_DOOR;
            dec               = DEC_WALK;
          end else begin
            dec = DEC_EMIT;
          end
        end else if (close_req) begin
          last_was_close_next = 1'b1;
          dec                 = DEC_EMIT;
          emit_word = '{kind: KIND_CLOSE, door: current_door, fail_mask: '0};
        end else begin
          dec = DEC_WALK;
        end
      end
      ACT_TIMEOUT: begin
        dec = DEC_WALK;
        if (retry_door == current_door) begin
          if (retry_count < RETRY_LIMIT) begin
            retry_count_next = retry_count + RETRY_W'(1);
          end else begin
            retry_count_next = '0;
            if (current_door < LAST_DOOR) begin
              failed_doors_next = failed_doors | current_bit;
              current_door_next = current_door + FIRST_DOOR;
              walk_from         = current_door + FIRST_DOOR;
            end else begin
              dec = DEC_EMIT;
            end
          end
        end else begin
          retry_door_next  = current_door;
          retry_count_next = RETRY_W'(last_was_close);
        end
      end
      default: begin
        dec = DEC_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_door   <= FIRST_DOOR;
      retry_door     <= '0;
      retry_count    <= '0;
      failed_doors   <= '0;
      skipped_doors  <= '0;
      last_was_close <= 1'b0;
    end else if (cmd.take) begin
      current_door   <= current_door_next;
      retry_door     <= retry_door_next;
      retry_count    <= retry_count_next;
      failed_doors   <= failed_doors_next;
      skipped_doors  <= skipped_doors_next;
      last_was_close <= last_was_close_next;
    end else if (cmd.walk && walk_hit) begin
      current_door   <= walk_door;
      last_was_close <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      walk_door <= walk_from;
      if (dec == DEC_EMIT) begin
        out_data <= emit_word;
      end
    end else if (cmd.walk) begin
      if (walk_hit) begin
        out_data <= '{kind: KIND_QUERY, door: walk_door, fail_mask: '0};
      end else if (walk_door == LAST_DOOR) begin
        out_data <= '{kind: KIND_DONE, door: '0, fail_mask: failed_doors};
      end else begin
        walk_door <= walk_door + FIRST_DOOR;
      end
    end
  end

  assign stat.dec       = dec;
  assign stat.walk_done = walk_hit || (walk_door == LAST_DOOR);

endmodule

// ===== rtl/core/dprs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Door poll sequencer controller
// Sequences accept, skip walk and result delivery for one event at a time.
// ----------------------------------------------------------------------------
module dprs_ctrl import dprs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd.take   = 1'b0;
    cmd.walk   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid) begin
          case (stat.dec)
            DEC_WALK: state_next = ST_WALK;
            DEC_EMIT: state_next = ST_SEND;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_done) begin
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/door_poll_retry_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// Door poll and retry sequencer
// Turns start, reply and timeout events into query, close and done words.
// ----------------------------------------------------------------------------
// Each input word is decided in the cycle it is accepted. A word that needs a
// position query then walks the skip mask one door per cycle from the door it
// starts at, examining 1 to 9 doors before its result is shown. Close and done
// results that need no walk are shown the cycle after acceptance, and an
// unknown action gives no result and leaves the input ready for the next word.
// The result is held until taken, and the next word is accepted in the cycle
// after that.
module door_poll_retry_sequencer_unit import dprs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dprs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dprs_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ===== tb/door_poll_retry_sequencer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Door poll and retry sequencer testbench
// Sends start, reply and timeout words through the valid/ready input channel and
// checks every command word against a model of the polling sequence kept in this
// testbench or a directed row's word. A short directed table opens the run, then
// random polling sequences with timeout bursts, random gaps and output stalls.
// ----------------------------------------------------------------------------
module door_poll_retry_sequencer_unit_tb;
  import dprs_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 750;
  localparam int CYCLE_LIMIT = 400000;
  localparam int QUIET_CYCLES = 40;

  typedef struct {
    in_word_t  word;
    logic      typed;
    out_word_t want;
  } stim_row_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  stim_row_t directed_rows[$];
  out_word_t pending_cmds[$];
  int        mismatches = 0;
  int        cycles = 0;
  logic      calm = 1'b0;

  logic [DOOR_W-1:0]  m_cur_door;
  logic [DOOR_W-1:0]  m_retry_door;
  logic [RETRY_W-1:0] m_retry_count;
  logic [MASK_W-1:0]  m_failed;
  logic [MASK_W-1:0]  m_skipped;
  logic               m_last_close;

  door_poll_retry_sequencer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("door_poll_retry_sequencer_unit_tb: FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic out_word_t done_word();
    out_word_t w;
    w.kind = KIND_DONE;
    w.door = '0;
    w.fail_mask = m_failed;
    return w;
  endfunction

  // Walks forward from door d past skipped doors and queries the first one left.
  function automatic out_word_t poll_from(input logic [DOOR_W-1:0] d);
    out_word_t w;
    logic found;
    int k;
    w = done_word();
    found = 1'b0;
    for (k = d; k <= NUM_DOORS; k++) begin
      if (!found && !m_skipped[k-1]) begin
        found = 1'b1;
        m_cur_door = DOOR_W'(k);
        m_last_close = 1'b0;
        w.kind = KIND_QUERY;
        w.door = DOOR_W'(k);
        w.fail_mask = '0;
      end
    end
    return w;
  endfunction

  function automatic out_word_t advance_door();
    if (m_cur_door < LAST_DOOR) begin
      m_cur_door = m_cur_door + 1'b1;
      return poll_from(m_cur_door);
    end
    return done_word();
  endfunction

  function automatic out_word_t close_cmd();
    out_word_t w;
    m_last_close = 1'b1;
    w.kind = KIND_CLOSE;
    w.door = m_cur_door;
    w.fail_mask = '0;
    return w;
  endfunction

  function automatic logic next_command(input in_word_t w, output out_word_t cmd);
    cmd = '0;
    case (w.action)
      ACT_START: begin
        m_skipped = w.skip_mask;
        m_cur_door = FIRST_DOOR;
        m_failed = '0;
        cmd = poll_from(FIRST_DOOR);
      end
      ACT_REPLY: begin
        if (w.reply_code == CODE_POSITION) begin
          cmd = (w.reply_status == STATUS_CLOSED) ? advance_door() : close_cmd();
        end else if (w.reply_code == CODE_CLOSE) begin
          cmd = (w.reply_status == STATUS_SUCCESS) ? advance_door() : close_cmd();
        end else begin
          cmd = poll_from(m_cur_door);
        end
      end
      ACT_TIMEOUT: begin
        if (m_retry_door == m_cur_door) begin
          if (m_retry_count < RETRY_LIMIT) begin
            m_retry_count = m_retry_count + 1'b1;
          end else begin
            m_retry_count = '0;
            if (m_cur_door < LAST_DOOR) begin
              m_failed[m_cur_door-1] = 1'b1;
              m_cur_door = m_cur_door + 1'b1;
            end else begin
              cmd = done_word();
              return 1'b1;
            end
          end
        end else begin
          m_retry_door = m_cur_door;
          m_retry_count = m_last_close ? RETRY_W'(1) : RETRY_W'(0);
        end
        cmd = poll_from(m_cur_door);
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic in_word_t random_word(input logic [1:0] act);
    in_word_t w;
    int r;
    w.action = act;
    w.skip_mask = MASK_W'($urandom);
    w.reply_code = 8'($urandom);
    w.reply_status = 8'($urandom);
    if (act == ACT_START && $urandom_range(0, 3) != 0) begin
      w.skip_mask = MASK_W'($urandom & $urandom);
    end
    r = $urandom_range(0, 99);
    if (r < 40) w.reply_code = CODE_POSITION;
    else if (r < 75) w.reply_code = CODE_CLOSE;
    r = $urandom_range(0, 99);
    if (r < 40) w.reply_status = STATUS_SUCCESS;
    else if (r < 80) w.reply_status = STATUS_CLOSED;
    return w;
  endfunction

  task automatic add_row(input logic [1:0] act, input logic [MASK_W-1:0] mask,
                         input logic [7:0] code, input logic [7:0] status,
                         input logic typed, input logic [1:0] kind,
                         input logic [DOOR_W-1:0] door, input logic [MASK_W-1:0] fails);
    stim_row_t row;
    row.word.action = act;
    row.word.skip_mask = mask;
    row.word.reply_code = code;
    row.word.reply_status = status;
    row.typed = typed;
    row.want.kind = kind;
    row.want.door = door;
    row.want.fail_mask = fails;
    directed_rows.push_back(row);
  endtask

  task automatic drive_word(input in_word_t w, input logic typed, input out_word_t want);
    int gap;
    out_word_t cmd;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    if (next_command(w, cmd)) pending_cmds.push_back(typed ? want : cmd);
  endtask

  task automatic check_command(input out_word_t got);
    out_word_t want;
    if (pending_cmds.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch %0d: unexpected word kind=%0d door=%0d fail_mask=%h",
                 mismatches, got.kind, got.door, got.fail_mask);
      end
    end else begin
      want = pending_cmds.pop_front();
      if (got.kind !== want.kind || got.door !== want.door ||
          got.fail_mask !== want.fail_mask) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch %0d: expected kind=%0d door=%0d fail_mask=%h,",
                   mismatches, want.kind, want.door, want.fail_mask,
                   " got kind=%0d door=%0d fail_mask=%h",
                   got.kind, got.door, got.fail_mask);
        end
      end
    end
  endtask

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_command(out_data);
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < 30) stall = pick_gap();
      end
    end
  end

  initial begin
    int i;
    int r;
    int burst;
    int sent;
    in_word_t w;
    m_cur_door = FIRST_DOOR;
    m_retry_door = '0;
    m_retry_count = '0;
    m_failed = '0;
    m_skipped = '0;
    m_last_close = 1'b0;

    // Reply before any start, then a fully skipped start and a full walk with
    // close commands, close timeouts, retries and a door given up on.
    add_row(ACT_REPLY, 9'h000, 8'h05, 8'h00, 1'b1, KIND_QUERY, 4'd1, 9'h000);
    add_row(ACT_START, 9'h1FF, 8'h00, 8'h00, 1'b1, KIND_DONE, 4'd0, 9'h000);
    add_row(ACT_START, 9'h000, 8'hFF, 8'hFF, 1'b1, KIND_QUERY, 4'd1, 9'h000);
    add_row(ACT_REPLY, 9'h1FF, CODE_POSITION, STATUS_CLOSED, 1'b0, '0, '0, '0);
    add_row(ACT_REPLY, 9'h000, CODE_POSITION, 8'h00, 1'b0, '0, '0, '0);
    add_row(ACT_REPLY, 9'h000, CODE_CLOSE, 8'hFF, 1'b0, '0, '0, '0);
    for (i = 0; i < 4; i++) add_row(ACT_TIMEOUT, 9'h0AA, 8'h00, 8'h00, 1'b0, '0, '0, '0);
    add_row(ACT_REPLY, 9'h155, CODE_CLOSE, STATUS_SUCCESS, 1'b0, '0, '0, '0);
    add_row(ACT_UNUSED, 9'h1FF, 8'hFF, 8'hFF, 1'b0, '0, '0, '0);
    add_row(ACT_REPLY, 9'h000, 8'hFF, 8'h80, 1'b0, '0, '0, '0);
    // Only the last door left: its give-up reports done without a fail bit.
    add_row(ACT_START, 9'h0FF, 8'h00, 8'h00, 1'b1, KIND_QUERY, 4'd9, 9'h000);
    for (i = 0; i < 4; i++) add_row(ACT_TIMEOUT, 9'h000, 8'h00, 8'h00, 1'b0, '0, '0, '0);
    add_row(ACT_TIMEOUT, 9'h000, 8'h00, 8'h00, 1'b1, KIND_DONE, 4'd0, 9'h000);
    // Only the first door left: its give-up is flagged and the walk runs off the end.
    add_row(ACT_START, 9'h1FE, 8'h00, 8'h00, 1'b1, KIND_QUERY, 4'd1, 9'h000);
    for (i = 0; i < 4; i++) add_row(ACT_TIMEOUT, 9'h000, 8'h00, 8'h00, 1'b0, '0, '0, '0);
    add_row(ACT_TIMEOUT, 9'h000, 8'h00, 8'h00, 1'b1, KIND_DONE, 4'd0, 9'h001);
    add_row(ACT_START, 9'h0FF, 8'h00, 8'h00, 1'b1, KIND_QUERY, 4'd9, 9'h000);
    add_row(ACT_REPLY, 9'h000, CODE_POSITION, STATUS_CLOSED, 1'b1, KIND_DONE, 4'd0, 9'h000);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[row_idx]) begin
      drive_word(directed_rows[row_idx].word, directed_rows[row_idx].typed,
                 directed_rows[row_idx].want);
    end

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if (sent % 64 < 6) calm = (sent % 128 < 6);
      r = $urandom_range(0, 99);
      if (r < 6) begin
        drive_word(random_word(ACT_START), 1'b0, '0);
        sent++;
      end else if (r < 40) begin
        burst = $urandom_range(1, 5);
        repeat (burst) drive_word(random_word(ACT_TIMEOUT), 1'b0, '0);
        sent += burst;
      end else if (r < 97) begin
        drive_word(random_word(ACT_REPLY), 1'b0, '0);
        sent++;
      end else begin
        drive_word(random_word(ACT_UNUSED), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("door_poll_retry_sequencer_unit_tb: PASS");
    end else begin
      $display("door_poll_retry_sequencer_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
